### design/bda_pkg.sv
`default_nettype none

package bda_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int SHIFT_W    = $clog2(VALUE_W);
    localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
    localparam logic [SHIFT_W-1:0] LAST_SHIFT   = SHIFT_W'(VALUE_W - 1);
    localparam logic [DCNT_W-1:0]  FULL_DIGITS  = DCNT_W'(NUM_DIGITS);
    localparam logic [DCNT_W-1:0]  ONE_DIGIT    = DCNT_W'(1);
    localparam logic [3:0]         ADJ_LIMIT    = 4'd5;
    localparam logic [3:0]         ADJ_ADD      = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } bda_state_t;

endpackage

`default_nettype wire

### design/binary_to_decimal_ascii_unit.sv
// binary to decimal ascii converter
//
// slave channel s_*: one word carries a 32-bit unsigned value in s_tdata.
// master channel m_*: one word per decimal digit, most significant first,
// leading zeros dropped; m_tdata[5:0] is the ascii code, m_tlast marks the
// final digit. zero gives the single character '0' with m_tlast set.
//
// timing: after a value is taken, a shift-and-add-3 sequencer runs one bit
// per cycle through every bit of the value, then checks the top digit and
// drops each leading zero (up to 9), then presents one digit per cycle while
// m_tready is high. dropped zeros plus digits always make ten, and the next
// input word is taken only after the final digit has been taken.
//
// one item is worked on at a time: s_tready is high only while the unit is
// idle. when the receiver stalls, the current digit and m_tlast hold until
// taken.
// reset returns the sequencer to idle with no output pending.
`default_nettype none

module binary_to_decimal_ascii_unit
    import bda_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // digit_char[5:0], zero pad[7:6]
    output logic             m_tlast
);

    bda_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;

    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= ADJ_LIMIT)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + ADJ_ADD;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        shift_next = shift_reg;
        dcnt_next  = dcnt_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        m_tdata    = {2'b00, ASCII_ZERO + {2'b00, top_digit}};

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    bin_next   = s_tdata;
                    bcd_next   = '0;
                    shift_next = '0;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                shift_next = shift_reg + 1'b1;
                if (shift_reg == LAST_SHIFT)
                begin
                    dcnt_next  = FULL_DIGITS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && dcnt_reg != ONE_DIGIT)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = (dcnt_reg == ONE_DIGIT);
                if (m_tready)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                    if (dcnt_reg == ONE_DIGIT)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> top_digit <= 4'd9)
        else $error("digit out of decimal range");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a digit is pending");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> dcnt_reg != '0 && dcnt_reg <= FULL_DIGITS)
        else $error("digit count out of range while emitting");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("unit not idle after final digit");

endmodule

`default_nettype wire
